// ===== hw/rtl/slt_pkg.sv =====
// Shared types, constants and byte-class helpers for the separated list tokenizer.
// No dependencies; imported by the interfaces, the element RAM user and the top level.
`default_nettype none

package slt_pkg;

	localparam int BYTE_W        = 8;
	localparam int ELEMENT_BYTES = 63;
	localparam int CNT_W         = $clog2(ELEMENT_BYTES + 1);
	localparam int ADDR_W        = (ELEMENT_BYTES > 1) ? $clog2(ELEMENT_BYTES) : 1;
	localparam int SEP_SET_W     = 9;
	localparam int BUF_LIM_W     = 7;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 9;

	localparam logic [BYTE_W-1:0]    SEP_DEFAULT   = 8'h3A;
	localparam logic [BYTE_W-1:0]    LT_BYTE       = 8'h3C;
	localparam logic [BUF_LIM_W-1:0] BUF_LIM_RESET = 7'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_SETTING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUF_LIMIT   = 1'd1;

	// list parsing phase
	typedef enum logic [2:0] {
		PH_START,
		PH_LT,
		PH_SKIP,
		PH_ELEM,
		PH_PEND
	} phase_t;

	// sequencer state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_EMIT,
		ST_POST
	} state_t;

	// outcome of one byte fed into an element phase
	typedef struct packed {
		logic   emit;
		logic   store;
		phase_t nxt;
	} feed_dec_t;

	function automatic logic is_space(input logic [BYTE_W-1:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic logic is_cntrl(input logic [BYTE_W-1:0] b);
		return (b < 8'd32) || (b == 8'd127);
	endfunction

	function automatic logic is_punct(input logic [BYTE_W-1:0] b);
		return ((b >= 8'd33) && (b <= 8'd47)) || ((b >= 8'd58) && (b <= 8'd64)) ||
		       ((b >= 8'd91) && (b <= 8'd96)) || ((b >= 8'd123) && (b <= 8'd126));
	endfunction

	// one byte through skip / element / pending-separator phases;
	// an emit always comes before the store it is paired with
	function automatic feed_dec_t feed_eval(
		input phase_t            ph,
		input logic [BYTE_W-1:0] b,
		input logic              fin,
		input logic [BYTE_W-1:0] sep,
		input logic              sctl
	);
		feed_dec_t d;
		logic      go_elem;
		d.emit  = 1'b0;
		d.store = 1'b0;
		d.nxt   = ph;
		go_elem = 1'b0;
		case (ph)
			PH_SKIP: begin
				if (fin) begin
					d.nxt = PH_START;
				end else if (!(is_space(b) && (b != sep))) begin
					go_elem = 1'b1;
				end
			end
			PH_ELEM: begin
				if (fin) begin
					d.emit = 1'b1;
					d.nxt  = PH_START;
				end else begin
					go_elem = 1'b1;
				end
			end
			PH_PEND: begin
				if (fin) begin
					d.emit = 1'b1;
					d.nxt  = PH_START;
				end else if (b == sep) begin
					d.store = 1'b1;
					d.nxt   = PH_ELEM;
				end else begin
					d.emit = 1'b1;
					if (is_space(b)) begin
						d.nxt = PH_SKIP;
					end else begin
						d.store = 1'b1;
						d.nxt   = PH_ELEM;
					end
				end
			end
			default: begin
				d.nxt = PH_START;
			end
		endcase
		if (go_elem) begin
			if (b == sep) begin
				if (sctl) begin
					d.emit = 1'b1;
					d.nxt  = PH_SKIP;
				end else begin
					d.nxt = PH_PEND;
				end
			end else begin
				d.store = 1'b1;
				d.nxt   = PH_ELEM;
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slt_if.sv =====
// Valid/ready channel interfaces for list bytes in and element bytes out.
// Depends on slt_pkg for the byte width.
`default_nettype none

interface slt_byte_if
	import slt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              is_end;

	modport source (output valid, output in_byte, output is_end, input ready);
	modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface slt_elem_if
	import slt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              elem_last;
	logic              elem_empty;
	logic [BYTE_W-1:0] sep_in_use;

	modport source (output valid, output out_byte, output elem_last, output elem_empty,
		output sep_in_use, input ready);
	modport sink   (input valid, input out_byte, input elem_last, input elem_empty,
		input sep_in_use, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency; width and depth come from parameters.
`default_nettype none

module slt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read-first registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/separated_list_tokenizer.sv =====
// Separated list tokenizer top level: parsing sequencer, element store, output register.
// Depends on slt_pkg, slt_if (slt_byte_if, slt_elem_if) and slt_ram.
//
//  channel   dir  handshake          payload
//  byte_ch   in   valid/ready        in_byte[7:0], is_end
//  elem_ch   out  valid/ready        out_byte[7:0], elem_last, elem_empty, sep_in_use[7:0]
//  cfg       in   cfg_wr_en          cfg_index[0], cfg_wdata[8:0]
//
// Bytes that only settle the separator at list start (leading blanks, '<' and the byte
// after it, an end mark) are taken in ST_IDLE alone; any other list byte also takes a
// feed step (ST_FEED) into the element RAM after its transaction. A '<' that turns out
// to be data is fed first, then the held byte. Closing an element reads its results in
// ST_EMIT, one RAM read at a time as the output register frees; ST_POST then closes it.
// Reset returns to the start of a list with sep_setting 0 and buf_limit 64; no clearing pass.
// The output register holds a result under stall while the next byte is accepted.
`default_nettype none

module separated_list_tokenizer
	import slt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	slt_byte_if.sink                   byte_ch,
	slt_elem_if.source                 elem_ch,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration
	logic [SEP_SET_W-1:0] sep_setting_q;
	logic [BUF_LIM_W-1:0] buf_limit_q;

	// control state
	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] sep_q, sep_d;
	logic              sctl_q, sctl_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  trim_q, trim_d;
	logic              lt_pend_q, lt_pend_d;
	feed_dec_t         post_q, post_d;
	logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;

	// work byte payload
	logic [BYTE_W-1:0] work_byte_q, work_byte_d;
	logic              work_end_q, work_end_d;
	logic [BYTE_W-1:0] hold_byte_q, hold_byte_d;

	// read pipeline and output register
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic              rd_empty_s1;
	logic [BYTE_W-1:0] rd_sep_s1;
	logic [BYTE_W-1:0] rd_data;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic [BYTE_W-1:0] out_sep_q;

	// combinational helpers
	feed_dec_t            fd;
	logic                 issue;
	logic                 issue_ok;
	logic                 is_last;
	logic                 store_req;
	logic                 clear_cnt;
	logic                 do_write;
	logic [CNT_W-1:0]     base_cnt;
	logic [CNT_W-1:0]     base_trim;
	logic [BUF_LIM_W-1:0] lim_m1;
	logic [BUF_LIM_W-1:0] keep;
	logic                 sep_fixed;
	logic [SEP_SET_W-1:0] sep_mag;
	logic [BYTE_W-1:0]    def_sep;
	logic                 out_fire;

	// separator chosen at list start
	assign sep_fixed = !sep_setting_q[SEP_SET_W-1] && (sep_setting_q != '0);
	assign sep_mag   = SEP_SET_W'(~sep_setting_q + SEP_SET_W'(1));
	assign def_sep   = (sep_setting_q[SEP_SET_W-1] && !sep_mag[SEP_SET_W-1])
		? sep_mag[BYTE_W-1:0] : SEP_DEFAULT;

	assign fd       = feed_eval(phase_q, work_byte_q, work_end_q, sep_q, sctl_q);
	assign out_fire = out_valid_q && elem_ch.ready;
	assign issue_ok = !rd_vld_s1 && (!out_valid_q || elem_ch.ready);
	assign is_last  = (trim_q == '0) || (rd_ptr_q == CNT_W'(trim_q - CNT_W'(1)));

	assign byte_ch.ready = (state_q == ST_IDLE);

	// sequencer next state
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		sep_d       = sep_q;
		sctl_d      = sctl_q;
		lt_pend_d   = lt_pend_q;
		post_d      = post_q;
		rd_ptr_d    = rd_ptr_q;
		work_byte_d = work_byte_q;
		work_end_d  = work_end_q;
		hold_byte_d = hold_byte_q;
		issue       = 1'b0;
		store_req   = 1'b0;
		clear_cnt   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (byte_ch.valid) begin
					work_byte_d = byte_ch.in_byte;
					work_end_d  = byte_ch.is_end;
					case (phase_q)
						PH_START: begin
							if (byte_ch.is_end) begin
								phase_d = PH_START;
							end else if (sep_fixed) begin
								sep_d   = sep_setting_q[BYTE_W-1:0];
								sctl_d  = is_cntrl(sep_setting_q[BYTE_W-1:0]);
								phase_d = PH_SKIP;
								state_d = ST_FEED;
							end else if (is_space(byte_ch.in_byte)) begin
								phase_d = PH_START;
							end else if (byte_ch.in_byte == LT_BYTE) begin
								phase_d = PH_LT;
							end else begin
								sep_d   = def_sep;
								sctl_d  = is_cntrl(def_sep);
								phase_d = PH_SKIP;
								state_d = ST_FEED;
							end
						end
						PH_LT: begin
							if (byte_ch.is_end) begin
								sep_d   = '0;
								sctl_d  = 1'b1;
								phase_d = PH_START;
							end else if (is_punct(byte_ch.in_byte) ||
							             is_cntrl(byte_ch.in_byte)) begin
								sep_d   = byte_ch.in_byte;
								sctl_d  = is_cntrl(byte_ch.in_byte);
								phase_d = PH_SKIP;
							end else begin
								// the '<' is element data, then the byte itself
								sep_d       = def_sep;
								sctl_d      = is_cntrl(def_sep);
								phase_d     = PH_SKIP;
								work_byte_d = LT_BYTE;
								work_end_d  = 1'b0;
								hold_byte_d = byte_ch.in_byte;
								lt_pend_d   = 1'b1;
								state_d     = ST_FEED;
							end
						end
						default: begin
							state_d = ST_FEED;
						end
					endcase
				end
			end
			ST_FEED: begin
				if (fd.emit) begin
					post_d  = fd;
					state_d = ST_EMIT;
				end else begin
					phase_d   = fd.nxt;
					store_req = fd.store;
					if (lt_pend_q) begin
						work_byte_d = hold_byte_q;
						lt_pend_d   = 1'b0;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (issue_ok) begin
					issue = 1'b1;
					if (is_last) begin
						rd_ptr_d = '0;
						state_d  = ST_POST;
					end else begin
						rd_ptr_d = CNT_W'(rd_ptr_q + CNT_W'(1));
					end
				end
			end
			ST_POST: begin
				clear_cnt = 1'b1;
				phase_d   = post_q.nxt;
				store_req = post_q.store;
				if (lt_pend_q) begin
					work_byte_d = hold_byte_q;
					lt_pend_d   = 1'b0;
					state_d     = ST_FEED;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// element store write and count / trimmed length tracking
	assign base_cnt  = clear_cnt ? '0 : count_q;
	assign base_trim = clear_cnt ? '0 : trim_q;
	assign lim_m1    = BUF_LIM_W'(buf_limit_q - BUF_LIM_W'(1));
	assign keep      = (buf_limit_q == '0) ? '0 :
		((lim_m1 > BUF_LIM_W'(ELEMENT_BYTES)) ? BUF_LIM_W'(ELEMENT_BYTES) : lim_m1);
	assign do_write  = store_req && (BUF_LIM_W'(base_cnt) < keep);
	assign count_d   = do_write ? CNT_W'(base_cnt + CNT_W'(1)) : base_cnt;
	assign trim_d    = (do_write && !is_space(work_byte_q))
		? CNT_W'(base_cnt + CNT_W'(1)) : base_trim;

	slt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (ELEMENT_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (base_cnt[ADDR_W-1:0]),
		.wr_data (work_byte_q),
		.rd_addr (rd_ptr_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_setting_q <= '0;
			buf_limit_q   <= BUF_LIM_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SEP_SETTING: sep_setting_q <= cfg_wdata[SEP_SET_W-1:0];
				CFG_BUF_LIMIT:   buf_limit_q   <= cfg_wdata[BUF_LIM_W-1:0];
				default:         buf_limit_q   <= buf_limit_q;
			endcase
		end
	end

	// sequencer and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_START;
			sep_q     <= '0;
			sctl_q    <= 1'b0;
			count_q   <= '0;
			trim_q    <= '0;
			lt_pend_q <= 1'b0;
			post_q    <= '{emit: 1'b0, store: 1'b0, nxt: PH_START};
			rd_ptr_q  <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			sep_q     <= sep_d;
			sctl_q    <= sctl_d;
			count_q   <= count_d;
			trim_q    <= trim_d;
			lt_pend_q <= lt_pend_d;
			post_q    <= post_d;
			rd_ptr_q  <= rd_ptr_d;
		end
	end

	// work byte payload
	always_ff @(posedge clk) begin
		work_byte_q <= work_byte_d;
		work_end_q  <= work_end_d;
		hold_byte_q <= hold_byte_d;
	end

	// read pipeline stage alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1  <= is_last;
		rd_empty_s1 <= (trim_q == '0);
		rd_sep_s1   <= sep_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_vld_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			out_byte_q  <= rd_empty_s1 ? '0 : rd_data;
			out_last_q  <= rd_last_s1;
			out_empty_q <= rd_empty_s1;
			out_sep_q   <= rd_sep_s1;
		end
	end

	assign elem_ch.valid      = out_valid_q;
	assign elem_ch.out_byte   = out_byte_q;
	assign elem_ch.elem_last  = out_last_q;
	assign elem_ch.elem_empty = out_empty_q;
	assign elem_ch.sep_in_use = out_sep_q;

`ifndef NO_ASSERTIONS
	// no element bytes linger outside an element
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_START || phase_q == PH_SKIP) |-> (count_q == '0))
		else $error("element store not empty at list start or skip phase");

	a_trim_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		trim_q <= count_q)
		else $error("trimmed length exceeds stored count");

	// read data must always find a free output register
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !out_valid_q)
		else $error("RAM read data arrived while output register busy");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> out_last_q)
		else $error("empty element result without last mark");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for separated_list_tokenizer: directed and random lists,
// with results checked against a tokenizer predictor kept inside the bench.
// Depends on slt_pkg, slt_if (slt_byte_if, slt_elem_if) and the tokenizer RTL.

module tb_top;
	import slt_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 10;
	localparam int QUIET_CYCLES = 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 220;
	localparam int MAX_REPORTS  = 10;

	// one element byte as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              empty;
		logic [BYTE_W-1:0] sep;
	} elem_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	slt_byte_if byte_ch ();
	slt_elem_if elem_ch ();

	separated_list_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.elem_ch   (elem_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// expected element beats, oldest first
	elem_beat_t beats_due[$];

	int mismatch_count = 0;
	int items_sent     = 0;
	int beats_checked  = 0;
	int lists_sent     = 0;
	int cfg_writes     = 0;
	int idle_cycles    = 0;
	bit no_gap         = 1'b0;

	// predictor copy of registers and tokenizer state
	int                tok_sep_setting = 0;
	int                tok_buf_limit   = 64;
	phase_t            tok_phase       = PH_START;
	logic [BYTE_W-1:0] tok_sep         = '0;
	bit                tok_sep_ctl     = 1'b0;
	logic [BYTE_W-1:0] tok_store [ELEMENT_BYTES];
	int                tok_cnt         = 0;

	// clock
	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	// C-locale byte classes
	function automatic bit is_blank(input logic [BYTE_W-1:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic bit is_ctl(input logic [BYTE_W-1:0] b);
		return (b < 8'd32) || (b == 8'd127);
	endfunction

	function automatic bit is_mark(input logic [BYTE_W-1:0] b);
		return ((b >= 8'd33) && (b <= 8'd47)) || ((b >= 8'd58) && (b <= 8'd64)) ||
			((b >= 8'd91) && (b <= 8'd96)) || ((b >= 8'd123) && (b <= 8'd126));
	endfunction

	// separator taken when the list does not pick its own
	function automatic logic [BYTE_W-1:0] fallback_sep();
		int mag;
		mag = (tok_sep_setting < 0) ? -tok_sep_setting : 0;
		return ((mag == 0) || (mag > 255)) ? SEP_DEFAULT : BYTE_W'(mag);
	endfunction

	task automatic queue_beat(input logic [BYTE_W-1:0] b, input bit last, input bit empty);
		elem_beat_t beat;
		beat.data  = b;
		beat.last  = last;
		beat.empty = empty;
		beat.sep   = tok_sep;
		beats_due.push_back(beat);
	endtask

	// trim trailing blanks and emit the element, or one empty beat
	task automatic close_element();
		int n;
		int i;
		n = tok_cnt;
		while ((n > 0) && is_blank(tok_store[n-1]))
			n--;
		if (n == 0) begin
			queue_beat(8'h00, 1'b1, 1'b1);
		end else begin
			for (i = 0; i < n; i++)
				queue_beat(tok_store[i], (i + 1 == n), 1'b0);
		end
		tok_cnt = 0;
	endtask

	task automatic keep_byte(input logic [BYTE_W-1:0] b);
		int cap;
		cap = (tok_buf_limit == 0) ? 0 : tok_buf_limit - 1;
		if (cap > ELEMENT_BYTES)
			cap = ELEMENT_BYTES;
		if (tok_cnt < cap) begin
			tok_store[tok_cnt] = b;
			tok_cnt++;
		end
	endtask

	// one byte through the skip, element and pending-separator phases
	task automatic advance_element(input logic [BYTE_W-1:0] b, input bit fin);
		bit again;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (tok_phase)
				PH_SKIP: begin
					if (fin) begin
						tok_phase = PH_START;
					end else if (!(is_blank(b) && (b != tok_sep))) begin
						tok_cnt   = 0;
						tok_phase = PH_ELEM;
						again     = 1'b1;
					end
				end
				PH_ELEM: begin
					if (fin) begin
						close_element();
						tok_phase = PH_START;
					end else if (b == tok_sep) begin
						if (tok_sep_ctl) begin
							close_element();
							tok_phase = PH_SKIP;
						end else begin
							tok_phase = PH_PEND;
						end
					end else begin
						keep_byte(b);
					end
				end
				PH_PEND: begin
					if (fin) begin
						close_element();
						tok_phase = PH_START;
					end else if (b == tok_sep) begin
						keep_byte(b);
						tok_phase = PH_ELEM;
					end else begin
						close_element();
						tok_phase = PH_SKIP;
						again     = 1'b1;
					end
				end
				default: begin
					tok_phase = PH_START;
				end
			endcase
		end
	endtask

	// expected beats for one accepted list byte or end mark
	task automatic predict_item(input logic [BYTE_W-1:0] b, input bit fin);
		case (tok_phase)
			PH_START: begin
				if (fin) begin
					// nothing open
				end else if (tok_sep_setting > 0) begin
					tok_sep     = BYTE_W'(tok_sep_setting);
					tok_sep_ctl = is_ctl(tok_sep);
					tok_phase   = PH_SKIP;
					advance_element(b, 1'b0);
				end else if (is_blank(b)) begin
					// leading blank before the separator is decided
				end else if (b == LT_BYTE) begin
					tok_phase = PH_LT;
				end else begin
					tok_sep     = fallback_sep();
					tok_sep_ctl = is_ctl(tok_sep);
					tok_phase   = PH_SKIP;
					advance_element(b, 1'b0);
				end
			end
			PH_LT: begin
				if (fin) begin
					tok_sep     = '0;
					tok_sep_ctl = 1'b1;
					tok_phase   = PH_START;
				end else if (is_mark(b) || is_ctl(b)) begin
					tok_sep     = b;
					tok_sep_ctl = is_ctl(b);
					tok_phase   = PH_SKIP;
				end else begin
					// the '<' was data after all
					tok_sep     = fallback_sep();
					tok_sep_ctl = is_ctl(tok_sep);
					tok_phase   = PH_SKIP;
					advance_element(LT_BYTE, 1'b0);
					advance_element(b, 1'b0);
				end
			end
			default: begin
				advance_element(b, fin);
			end
		endcase
		if (fin)
			tok_phase = PH_START;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_gap)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_blank();
		return ($urandom_range(0, 2) == 0) ? 8'd32 : BYTE_W'($urandom_range(9, 13));
	endfunction

	// one list byte transaction on the input channel
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			byte_ch.valid <= 1'b0;
		end
		@(negedge clk);
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.is_end  <= fin;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		predict_item(b, fin);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
		lists_sent++;
	endtask

	task automatic send_run(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_byte(8'h41 + BYTE_W'(i % 26), 1'b0);
	endtask

	// hold the input until every expected beat is out and the block is quiet
	task automatic settle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_SEP_SETTING)
			tok_sep_setting = $signed(value);
		else
			tok_buf_limit = value[BUF_LIM_W-1:0];
		cfg_writes++;
	endtask

	task automatic set_config(input int sep, input int lim);
		settle();
		cfg_write(CFG_SEP_SETTING, CFG_DATA_W'(sep));
		cfg_write(CFG_BUF_LIMIT, CFG_DATA_W'(lim));
	endtask

	task automatic test_default_lists();
		// leading blanks, zero byte, doubled and trailing separator, high byte
		send_text("  a");
		send_byte(8'h00, 1'b0);
		send_text(" :: b");
		send_byte(8'h80, 1'b0);
		send_text(":");
		send_end();
		// blank-only element and trailing blanks
		send_text("x: :y  ");
		send_end();
		// separator chosen by '<', then '<' as plain data
		send_text("<;u;v");
		send_end();
		send_text("<a:b");
		send_end();
		// lone '<' and an end mark on its own
		send_text("<");
		send_end();
		send_end();
	endtask

	task automatic test_separator_settings();
		// fixed top separator, '<' is data there
		set_config(255, 64);
		send_text("a");
		send_byte(8'hFF, 1'b0);
		send_text("<b");
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("c");
		send_end();
		// fixed control separator that is also a blank
		set_config(9, 64);
		send_text("\ta\t\tb");
		send_end();
		// changeable with the most negative settings
		set_config(-255, 64);
		send_text("x");
		send_byte(8'hFF, 1'b0);
		send_text("y");
		send_end();
		set_config(-256, 64);
		send_text("p:q");
		send_end();
		// changeable default ';', overridden in one list, then a control separator
		set_config(-59, 64);
		send_text("<|a|b;c");
		send_end();
		send_text("d;e");
		send_end();
		send_text("<");
		send_byte(8'h01, 1'b0);
		send_text("f");
		send_byte(8'h01, 1'b0);
		send_byte(8'h01, 1'b0);
		send_end();
	endtask

	task automatic test_buffer_limits();
		// nothing kept at all
		set_config(0, 0);
		send_text("ab:c");
		send_end();
		set_config(0, 1);
		send_text("ab");
		send_end();
		// truncation to one byte, trimming after truncation
		set_config(0, 2);
		send_text("abc: d e ");
		send_end();
		// store clamps at its full size
		set_config(0, 127);
		send_run(66);
		send_end();
		set_config(0, 64);
		send_run(65);
		send_end();
		// buf_limit changed inside a list takes effect at once
		send_text("abcdef");
		settle();
		cfg_write(CFG_BUF_LIMIT, CFG_DATA_W'(3));
		send_text("gh:ijkl");
		send_end();
		// sep_setting changed inside a list waits for the next list
		send_text("ab");
		settle();
		cfg_write(CFG_SEP_SETTING, CFG_DATA_W'(-59));
		send_text(";c:d");
		send_end();
		send_text("e;f");
		send_end();
	endtask

	task automatic test_random_lists();
		int                start_items;
		int                n_elems;
		int                e;
		int                k;
		int                len;
		int                r;
		int                cfg_sep;
		int                cfg_lim;
		logic [BYTE_W-1:0] gen_sep;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			// new register setting between lists now and then
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 5))
					0: cfg_sep = 0;
					1: cfg_sep = -$urandom_range(33, 47);
					2: cfg_sep = $urandom_range(1, 255);
					3: cfg_sep = -$urandom_range(1, 256);
					4: cfg_sep = $urandom_range(0, 511) - 256;
					default: cfg_sep = $urandom_range(33, 126);
				endcase
				r = $urandom_range(0, 9);
				if (r < 5)
					cfg_lim = $urandom_range(0, 8);
				else if (r < 7)
					cfg_lim = $urandom_range(9, 63);
				else if (r == 7)
					cfg_lim = 64;
				else if (r == 8)
					cfg_lim = 127;
				else
					cfg_lim = $urandom_range(0, 127);
				set_config(cfg_sep, cfg_lim);
			end
			no_gap = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise list
				len = $urandom_range(0, 12);
				for (k = 0; k < len; k++)
					send_byte(($urandom_range(0, 3) == 0) ? LT_BYTE :
						BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else begin
				gen_sep = (tok_sep_setting > 0) ? BYTE_W'(tok_sep_setting) : fallback_sep();
				if ((tok_sep_setting <= 0) && ($urandom_range(0, 2) == 0)) begin
					if ($urandom_range(0, 3) == 0) begin
						r       = $urandom_range(0, 32);
						gen_sep = (r == 32) ? 8'd127 : BYTE_W'(r);
					end else begin
						do
							gen_sep = BYTE_W'($urandom_range(33, 126));
						while (!is_mark(gen_sep));
					end
					send_byte(LT_BYTE, 1'b0);
					send_byte(gen_sep, 1'b0);
				end
				n_elems = $urandom_range(0, 5);
				for (e = 0; e < n_elems; e++) begin
					repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) :
						$urandom_range(0, 6);
					for (k = 0; k < len; k++) begin
						r = $urandom_range(0, 15);
						if (r == 0) begin
							send_byte(gen_sep, 1'b0);
							send_byte(gen_sep, 1'b0);
						end else if (r < 3) begin
							send_byte(pick_blank(), 1'b0);
						end else if (r == 3) begin
							send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
						end else begin
							send_byte(BYTE_W'($urandom_range(33, 126)), 1'b0);
						end
					end
					if ((e + 1 < n_elems) || ($urandom_range(0, 1) == 0))
						send_byte(gen_sep, 1'b0);
					// sender waits mid-list until the element is out
					if ($urandom_range(0, 24) == 0)
						settle();
				end
			end
			send_end();
			if ($urandom_range(0, 9) == 0)
				settle();
		end
		no_gap = 1'b0;
	endtask

	// output ready: short stalls mostly, a few long, some stall-free stretches
	initial begin : elem_ready_drive
		int run;
		bit level;
		elem_ch.ready = 1'b0;
		run   = 0;
		level = 1'b0;
		forever begin
			@(negedge clk);
			if (run <= 0) begin
				level = !level;
				if (level) begin
					run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 12);
				end else begin
					run = $urandom_range(0, 99);
					if (run < 70)
						run = $urandom_range(1, 3);
					else if (run < 95)
						run = $urandom_range(4, 10);
					else
						run = $urandom_range(20, 40);
				end
			end
			elem_ch.ready <= level;
			run--;
		end
	end

	// compare each output transaction with the oldest expected beat
	always @(posedge clk) begin : elem_check
		elem_beat_t want;
		if (arst_n && elem_ch.valid && elem_ch.ready) begin
			if (beats_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected beat: data %02h last %b empty %b sep %02h",
						elem_ch.out_byte, elem_ch.elem_last, elem_ch.elem_empty,
						elem_ch.sep_in_use);
			end else begin
				want = beats_due.pop_front();
				beats_checked++;
				if ((elem_ch.out_byte !== want.data) || (elem_ch.elem_last !== want.last) ||
						(elem_ch.elem_empty !== want.empty) ||
						(elem_ch.sep_in_use !== want.sep)) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("beat %0d: expected data %02h last %b empty %b sep %02h, got data %02h last %b empty %b sep %02h",
							beats_checked, want.data, want.last, want.empty, want.sep,
							elem_ch.out_byte, elem_ch.elem_last, elem_ch.elem_empty,
							elem_ch.sep_in_use);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin : stall_watch
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (elem_ch.valid && elem_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("timeout: no transaction for %0d cycles, %0d beats outstanding",
						idle_cycles, beats_due.size());
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		byte_ch.valid   = 1'b0;
		byte_ch.in_byte = '0;
		byte_ch.is_end  = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_default_lists();
		test_separator_settings();
		test_buffer_limits();
		test_random_lists();
		settle();

		$display("ran %0d lists, %0d list bytes, %0d element beats, %0d register writes",
			lists_sent, items_sent, beats_checked, cfg_writes);
		$display("fixed, default and in-list separators; element limits 0 to 127; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
